FILE: hw/rtl/kmw_pkg.sv
package kmw_pkg;

    localparam int VTX_W       = 6;
    localparam int WGT_W       = 16;
    localparam int TOTAL_W     = 24;
    localparam int EDGE_W      = 2 * VTX_W + WGT_W;
    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 256;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SHRD,
        S_SHCMP,
        S_INS,
        S_CLR,
        S_ERD,
        S_EGET,
        S_FARD,
        S_FACHK,
        S_FBRD,
        S_FBCHK,
        S_UNI,
        S_OUT
    } state_t;

    typedef struct packed {
        logic key_load;
        logic sh_rd;
        logic sh_move;
        logic sh_ins;
        logic clr_step;
        logic edge_rd;
        logic edge_get;
        logic par_rd;
        logic find_step;
        logic find_sel_b;
        logic union_step;
        logic count_clr;
    } cmd_t;

    typedef struct packed {
        logic store_ok;
        logic count_zero;
        logic key_before;
        logic j_one;
        logic clr_last;
        logic par_root;
        logic e_last;
        logic last_in;
        logic last_key;
    } status_t;

endpackage

FILE: hw/rtl/kmw_ram.sv
module kmw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/kmw_ctrl.sv
module kmw_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  kmw_pkg::status_t st,
    output kmw_pkg::cmd_t    cmd
);
    import kmw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (st.store_ok && st.count_zero) state_next = S_INS;
                    else if (st.store_ok)                      state_next = S_SHRD;
                    else if (st.last_in)                       state_next = S_CLR;
                    else                                       state_next = S_IDLE;
                end
            end
            S_SHRD:  state_next = S_SHCMP;
            S_SHCMP:
            begin
                if (st.key_before && !st.j_one) state_next = S_SHRD;
                else                            state_next = S_INS;
            end
            S_INS:   state_next = st.last_key ? S_CLR : S_IDLE;
            S_CLR:
            begin
                if (st.clr_last) state_next = st.count_zero ? S_OUT : S_ERD;
            end
            S_ERD:   state_next = S_EGET;
            S_EGET:  state_next = S_FARD;
            S_FARD:  state_next = S_FACHK;
            S_FACHK: state_next = st.par_root ? S_FBRD : S_FARD;
            S_FBRD:  state_next = S_FBCHK;
            S_FBCHK: state_next = st.par_root ? S_UNI : S_FBRD;
            S_UNI:   state_next = st.e_last ? S_OUT : S_ERD;
            S_OUT:
            begin
                if (!out_stall) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.key_load = in_valid;
            end
            S_SHRD:  cmd.sh_rd   = 1'b1;
            S_SHCMP: cmd.sh_move = st.key_before;
            S_INS:   cmd.sh_ins  = 1'b1;
            S_CLR:   cmd.clr_step = 1'b1;
            S_ERD:   cmd.edge_rd  = 1'b1;
            S_EGET:  cmd.edge_get = 1'b1;
            S_FARD:  cmd.par_rd   = 1'b1;
            S_FACHK: cmd.find_step = 1'b1;
            S_FBRD:  cmd.par_rd   = 1'b1;
            S_FBCHK:
            begin
                cmd.find_step  = 1'b1;
                cmd.find_sel_b = 1'b1;
            end
            S_UNI:   cmd.union_step = 1'b1;
            S_OUT:
            begin
                out_valid     = 1'b1;
                cmd.count_clr = !out_stall;
            end
            default: cmd = '0;
        endcase
    end

endmodule

FILE: hw/rtl/kmw_dp.sv
module kmw_dp #(
    parameter int MAX_VERTICES = kmw_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = kmw_pkg::DEF_MAX_EDGES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [kmw_pkg::VTX_W-1:0]    from_vertex,
    input  logic [kmw_pkg::VTX_W-1:0]    to_vertex,
    input  logic [kmw_pkg::WGT_W-1:0]    edge_weight,
    input  logic                         last_edge,
    input  kmw_pkg::cmd_t                cmd,
    output kmw_pkg::status_t             st,
    output logic [kmw_pkg::TOTAL_W-1:0]  tree_weight
);
    import kmw_pkg::*;

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int VX = (VW > VTX_W) ? VW : VTX_W;

    function automatic logic [VW-1:0] vtx(input logic [VTX_W-1:0] x);
        logic [VX-1:0] t;
        t = VX'(x);
        return t[VW-1:0];
    endfunction

    logic [VTX_W-1:0]   key_from_reg;
    logic [VTX_W-1:0]   key_to_reg;
    logic [WGT_W-1:0]   key_w_reg;
    logic               last_reg;
    logic [CW-1:0]      j_reg;
    logic [CW-1:0]      count_reg;
    logic [VW-1:0]      i_reg;
    logic [CW-1:0]      e_reg;
    logic [VW-1:0]      v_reg;
    logic [VW-1:0]      ra_reg;
    logic [VW-1:0]      rb_reg;
    logic [VW-1:0]      cur_to_reg;
    logic [WGT_W-1:0]   cur_w_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic [EDGE_W-1:0]  edge_rdata;
    logic [EDGE_W-1:0]  edge_wdata;
    logic               edge_we;
    logic [EW-1:0]      edge_raddr;
    logic [CW-1:0]      jm1;
    logic [VTX_W-1:0]   rd_from;
    logic [VTX_W-1:0]   rd_to;
    logic [WGT_W-1:0]   rd_w;
    logic [VW:0]        par_rdata;
    logic [VW:0]        par_wdata;
    logic [VW-1:0]      par_waddr;
    logic               par_we;
    logic [TOTAL_W:0]   sum;
    logic [CW-1:0]      e_inc;

    assign rd_from = edge_rdata[EDGE_W-1 -: VTX_W];
    assign rd_to   = edge_rdata[WGT_W +: VTX_W];
    assign rd_w    = edge_rdata[WGT_W-1:0];
    assign jm1     = j_reg - CW'(1);
    assign e_inc   = e_reg + CW'(1);
    assign sum     = {1'b0, total_reg} + (TOTAL_W + 1)'(cur_w_reg);

    assign edge_we    = cmd.sh_move | cmd.sh_ins;
    assign edge_wdata = cmd.sh_move ? edge_rdata : {key_from_reg, key_to_reg, key_w_reg};
    assign edge_raddr = cmd.sh_rd ? jm1[EW-1:0] : e_reg[EW-1:0];

    kmw_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES), .AW(EW)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (j_reg[EW-1:0]),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    assign par_we    = cmd.clr_step | (cmd.union_step && (ra_reg != rb_reg));
    assign par_waddr = cmd.clr_step ? i_reg : ra_reg;
    assign par_wdata = cmd.clr_step ? {1'b1, {VW{1'b0}}} : {1'b0, rb_reg};

    kmw_ram #(.WIDTH(VW + 1), .DEPTH(MAX_VERTICES), .AW(VW)) u_parent_ram (
        .clk   (clk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (par_wdata),
        .raddr (v_reg),
        .rdata (par_rdata)
    );

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            j_reg     <= '0;
            i_reg     <= '0;
            e_reg     <= '0;
            last_reg  <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            if (cmd.key_load)
            begin
                j_reg     <= count_reg;
                i_reg     <= '0;
                e_reg     <= '0;
                last_reg  <= last_edge;
                total_reg <= '0;
            end
            if (cmd.sh_move)
            begin
                j_reg <= jm1;
            end
            if (cmd.sh_ins)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.clr_step)
            begin
                i_reg <= i_reg + VW'(1);
            end
            if (cmd.union_step)
            begin
                e_reg <= e_inc;
                if (ra_reg != rb_reg)
                begin
                    total_reg <= sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
                end
            end
            if (cmd.count_clr)
            begin
                count_reg <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.key_load)
        begin
            key_from_reg <= from_vertex;
            key_to_reg   <= to_vertex;
            key_w_reg    <= edge_weight;
        end
        if (cmd.edge_get)
        begin
            v_reg      <= vtx(rd_from);
            cur_to_reg <= vtx(rd_to);
            cur_w_reg  <= rd_w;
        end
        if (cmd.find_step)
        begin
            if (par_rdata[VW])
            begin
                if (cmd.find_sel_b)
                begin
                    rb_reg <= v_reg;
                end
                else
                begin
                    ra_reg <= v_reg;
                    v_reg  <= cur_to_reg;
                end
            end
            else
            begin
                v_reg <= par_rdata[VW-1:0];
            end
        end
    end

    always_comb
    begin
        st            = '0;
        st.store_ok   = (32'(from_vertex) < 32'(MAX_VERTICES))
                     && (32'(to_vertex) < 32'(MAX_VERTICES))
                     && (count_reg < CW'(MAX_EDGES));
        st.count_zero = (count_reg == '0);
        st.key_before = (key_w_reg < rd_w) || ((key_w_reg == rd_w) && (key_from_reg < rd_from));
        st.j_one      = (j_reg == CW'(1));
        st.clr_last   = (i_reg == VW'(MAX_VERTICES - 1));
        st.par_root   = par_rdata[VW];
        st.e_last     = (e_inc == count_reg);
        st.last_in    = last_edge;
        st.last_key   = last_reg;
    end

    assign tree_weight = total_reg;

`ifndef SYNTH
    a_move_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sh_move |-> (j_reg != '0)) else $error("shift below entry zero");
    a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sh_ins |-> (count_reg < CW'(MAX_EDGES))) else $error("edge store overrun");
    a_edge_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.edge_rd |-> (e_reg < count_reg)) else $error("edge read past count");
`endif

endmodule

FILE: hw/rtl/kruskal_mst_weight.sv
// kruskal_mst_weight: minimum spanning forest weight
// input channel: one edge per request (from_vertex, to_vertex, edge_weight,
// last_edge) on in_valid / in_stall; edges with an endpoint out of range or
// arriving with the store full are dropped
// each stored edge is placed in weight order on arrival by an insertion walk
// through the edge memory that reads and compares each edge it passes
// a request with last_edge runs the computation: a clearing pass over all
// MAX_VERTICES entries of the parent memory, then per edge a read from the
// edge memory, a root walk from each endpoint and a union, the walks and the
// union going through the parent memory
// output channel: one tree_weight per last_edge request on out_valid /
// out_stall; the result is held while the receiver stalls and no new
// request is taken until it has gone
// reset empties the edge store and clears the total; nothing is emitted
module kruskal_mst_weight #(
    parameter int MAX_VERTICES = kmw_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = kmw_pkg::DEF_MAX_EDGES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [kmw_pkg::VTX_W-1:0]   from_vertex,
    input  logic [kmw_pkg::VTX_W-1:0]   to_vertex,
    input  logic [kmw_pkg::WGT_W-1:0]   edge_weight,
    input  logic                        last_edge,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [kmw_pkg::TOTAL_W-1:0] tree_weight
);
    import kmw_pkg::*;

    cmd_t    cmd;
    status_t st;

    kmw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    kmw_dp #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .from_vertex (from_vertex),
        .to_vertex   (to_vertex),
        .edge_weight (edge_weight),
        .last_edge   (last_edge),
        .cmd         (cmd),
        .st          (st),
        .tree_weight (tree_weight)
    );

endmodule
